// ===== src/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define CSDS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define CSDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/csds_pkg.sv =====
// Shared types and constants for the C-SCAN disk scheduler.
// Depends on nothing; used by the scheduler core and the verification files.
package csds_pkg;

   localparam int MAX_REQUESTS_DEF = 32;

   localparam int CYL_W   = 12;
   localparam int COST_W  = 13;
   localparam int MS_W    = 8;
   localparam int TOTAL_W = 20;
   localparam int SEEK_W  = 28;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic [CYL_W-1:0]  START_RST  = 12'd50;
   localparam logic [CYL_W-1:0]  TOP_RST    = 12'd199;
   localparam logic [COST_W-1:0] RETURN_RST = 13'd200;
   localparam logic [MS_W-1:0]   MS_RST     = 8'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETURN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MS     = 2'd3;

   localparam logic [KIND_W-1:0] KIND_SERVE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SWEEP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RETURN  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_CLOSE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_SWEEP,
      ST_RETURN,
      ST_LOW_RD,
      ST_LOW_CMP,
      ST_SUMMARY
   } state_type;

endpackage

// ===== src/csds_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; holds the sorted request list of the scheduler.
module csds_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // hold read data until the next read
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/cscan_disk_scheduler_core.sv =====
// C-SCAN disk scheduler: sorted request store and circular-scan service sequencer.
// Depends on csds_pkg, csds_ram and assert_macros.svh.
// Insertion: a read-compare-write walk through the request RAM shifts each larger stored entry up
//   one slot and writes the new request into the freed one; no request is taken during the walk.
// Service: close, an upward pass over the requests at or above the start, sweep, return, a lower
//   pass over the requests below the start and a summary, held by output stalls; N + 3 records.
// Reset (synchronous): config to defaults, batch empty, no RAM clearing pass.
`include "assert_macros.svh"

module cscan_disk_scheduler_core #(
   parameter int MAX_REQUESTS = csds_pkg::MAX_REQUESTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [csds_pkg::CYL_W-1:0]       req_cylinder,
   input  logic                             req_last_request,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [csds_pkg::KIND_W-1:0]      rsp_kind,
   output logic [csds_pkg::CYL_W-1:0]       rsp_from_cylinder,
   output logic [csds_pkg::CYL_W-1:0]       rsp_to_cylinder,
   output logic [csds_pkg::COST_W-1:0]      rsp_movement,
   output logic [csds_pkg::TOTAL_W-1:0]     rsp_total_movement,
   output logic [csds_pkg::SEEK_W-1:0]      rsp_seek_time,
   output logic                             rsp_overflow,
   output logic                             rsp_last_result,
   // configuration
   input  logic                             csr_we,
   input  logic [csds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [csds_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_REQUESTS + 1);
   localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_REQUESTS);

   // configuration registers
   logic [csds_pkg::CYL_W-1:0]  start_ff;
   logic [csds_pkg::CYL_W-1:0]  top_ff;
   logic [csds_pkg::COST_W-1:0] return_ff;
   logic [csds_pkg::MS_W-1:0]   ms_ff;

   // batch state
   csds_pkg::state_type          state_ff, state_in;
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                idx_ff;
   logic                         drop_ff;
   logic [csds_pkg::CYL_W-1:0]   head_ff;
   logic [csds_pkg::TOTAL_W-1:0] total_ff;
   logic [csds_pkg::CYL_W-1:0]   cyl_ff;
   logic                         last_ff;

   // output register
   logic                         rsp_valid_ff;
   logic [csds_pkg::KIND_W-1:0]  kind_ff;
   logic [csds_pkg::CYL_W-1:0]   from_ff;
   logic [csds_pkg::CYL_W-1:0]   to_ff;
   logic [csds_pkg::COST_W-1:0]  mv_ff;
   logic [csds_pkg::TOTAL_W-1:0] tot_out_ff;
   logic [csds_pkg::SEEK_W-1:0]  seek_ff;
   logic                         ovf_ff;
   logic                         last_out_ff;

   // RAM
   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [csds_pkg::CYL_W-1:0]   ram_wdata;
   logic                         ram_re;
   logic [AW-1:0]                ram_raddr;
   logic [csds_pkg::CYL_W-1:0]   ram_rdata;

   // control
   logic                         req_fire;
   logic                         out_free;
   logic                         out_load;
   logic [csds_pkg::KIND_W-1:0]  out_kind;
   logic [csds_pkg::CYL_W-1:0]   out_from;
   logic [csds_pkg::CYL_W-1:0]   out_to;
   logic [csds_pkg::COST_W-1:0]  out_mv;
   logic [csds_pkg::CYL_W-1:0]   dist_tgt;
   logic [csds_pkg::COST_W-1:0]  dist_mv;
   logic [csds_pkg::TOTAL_W:0]   total_sum;
   logic [csds_pkg::TOTAL_W-1:0] total_sat;
   logic                         insert_done;
   logic                         below_start;

   csds_ram #(
      .WIDTH (csds_pkg::CYL_W),
      .DEPTH (MAX_REQUESTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ready   = (state_ff == csds_pkg::ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign below_start = (ram_rdata < start_ff);
   assign insert_done = ((state_ff == csds_pkg::ST_INS_RD) && (idx_ff == '0))
                     || ((state_ff == csds_pkg::ST_INS_CMP) && !(ram_rdata > cyl_ff));

   // head distance, shared by service moves and the sweep
   assign dist_tgt = (state_ff == csds_pkg::ST_SWEEP) ? top_ff : ram_rdata;
   assign dist_mv  = (dist_tgt > head_ff) ? csds_pkg::COST_W'(dist_tgt - head_ff)
                                          : csds_pkg::COST_W'(head_ff - dist_tgt);

   assign total_sum = {1'b0, total_ff} + (csds_pkg::TOTAL_W + 1)'(out_mv);
   assign total_sat = total_sum[csds_pkg::TOTAL_W] ? csds_pkg::TOTAL_MAX
                                                   : total_sum[csds_pkg::TOTAL_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csds_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (count_ff == COUNT_FULL) begin
                  state_in = req_last_request ? csds_pkg::ST_CLOSE : csds_pkg::ST_IDLE;
               end else begin
                  state_in = csds_pkg::ST_INS_RD;
               end
            end
         end
         csds_pkg::ST_INS_RD: begin
            if (insert_done) begin
               state_in = last_ff ? csds_pkg::ST_CLOSE : csds_pkg::ST_IDLE;
            end else begin
               state_in = csds_pkg::ST_INS_CMP;
            end
         end
         csds_pkg::ST_INS_CMP: begin
            if (insert_done) begin
               state_in = last_ff ? csds_pkg::ST_CLOSE : csds_pkg::ST_IDLE;
            end else begin
               state_in = csds_pkg::ST_INS_RD;
            end
         end
         csds_pkg::ST_CLOSE: state_in = csds_pkg::ST_UP_RD;
         csds_pkg::ST_UP_RD: begin
            state_in = (idx_ff == count_ff) ? csds_pkg::ST_SWEEP : csds_pkg::ST_UP_CMP;
         end
         csds_pkg::ST_UP_CMP: begin
            if (below_start || out_free) begin
               state_in = csds_pkg::ST_UP_RD;
            end
         end
         csds_pkg::ST_SWEEP: begin
            if (out_free) begin
               state_in = csds_pkg::ST_RETURN;
            end
         end
         csds_pkg::ST_RETURN: begin
            if (out_free) begin
               state_in = csds_pkg::ST_LOW_RD;
            end
         end
         csds_pkg::ST_LOW_RD: begin
            state_in = (idx_ff == count_ff) ? csds_pkg::ST_SUMMARY : csds_pkg::ST_LOW_CMP;
         end
         csds_pkg::ST_LOW_CMP: begin
            if (!below_start) begin
               state_in = csds_pkg::ST_SUMMARY;
            end else if (out_free) begin
               state_in = csds_pkg::ST_LOW_RD;
            end
         end
         csds_pkg::ST_SUMMARY: begin
            if (out_free) begin
               state_in = csds_pkg::ST_IDLE;
            end
         end
         default: state_in = csds_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer: RAM accesses and record contents
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_wdata = cyl_ff;
      ram_re    = 1'b0;
      ram_raddr = idx_ff[AW-1:0];
      out_load  = 1'b0;
      out_kind  = csds_pkg::KIND_SERVE;
      out_from  = head_ff;
      out_to    = ram_rdata;
      out_mv    = dist_mv;
      unique case (state_ff)
         csds_pkg::ST_INS_RD: begin
            if (idx_ff == '0) begin
               ram_we = 1'b1;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = AW'(idx_ff - CW'(1));
            end
         end
         csds_pkg::ST_INS_CMP: begin
            // shift the larger entry up one place, or drop the new one in
            ram_we    = 1'b1;
            ram_wdata = (ram_rdata > cyl_ff) ? ram_rdata : cyl_ff;
         end
         csds_pkg::ST_UP_RD, csds_pkg::ST_LOW_RD: begin
            ram_re = (idx_ff != count_ff);
         end
         csds_pkg::ST_UP_CMP: begin
            out_load = !below_start && out_free;
         end
         csds_pkg::ST_LOW_CMP: begin
            out_load = below_start && out_free;
         end
         csds_pkg::ST_SWEEP: begin
            out_load = out_free;
            out_kind = csds_pkg::KIND_SWEEP;
            out_to   = top_ff;
         end
         csds_pkg::ST_RETURN: begin
            out_load = out_free;
            out_kind = csds_pkg::KIND_RETURN;
            out_from = top_ff;
            out_to   = '0;
            out_mv   = return_ff;
         end
         csds_pkg::ST_SUMMARY: begin
            out_load = out_free;
            out_kind = csds_pkg::KIND_SUMMARY;
            out_to   = head_ff;
            out_mv   = '0;
         end
         default: begin
         end
      endcase
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= csds_pkg::START_RST;
         top_ff    <= csds_pkg::TOP_RST;
         return_ff <= csds_pkg::RETURN_RST;
         ms_ff     <= csds_pkg::MS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            csds_pkg::CSR_START:  start_ff  <= csr_wdata[csds_pkg::CYL_W-1:0];
            csds_pkg::CSR_TOP:    top_ff    <= csr_wdata[csds_pkg::CYL_W-1:0];
            csds_pkg::CSR_RETURN: return_ff <= csr_wdata[csds_pkg::COST_W-1:0];
            csds_pkg::CSR_MS:     ms_ff     <= csr_wdata[csds_pkg::MS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // batch control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csds_pkg::ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire && (count_ff == COUNT_FULL)) begin
            drop_ff <= 1'b1;
         end
         if (insert_done) begin
            count_ff <= count_ff + CW'(1);
         end
         if ((state_ff == csds_pkg::ST_SUMMARY) && out_free) begin
            count_ff <= '0;
            drop_ff  <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cyl_ff  <= req_cylinder;
         last_ff <= req_last_request;
         idx_ff  <= count_ff;
      end
      unique case (state_ff)
         csds_pkg::ST_INS_CMP: begin
            if (ram_rdata > cyl_ff) begin
               idx_ff <= idx_ff - CW'(1);
            end
         end
         csds_pkg::ST_CLOSE: begin
            head_ff  <= start_ff;
            total_ff <= '0;
            idx_ff   <= '0;
         end
         csds_pkg::ST_UP_CMP, csds_pkg::ST_LOW_CMP: begin
            if (out_load) begin
               head_ff  <= ram_rdata;
               total_ff <= total_sat;
               idx_ff   <= idx_ff + CW'(1);
            end else if (state_ff == csds_pkg::ST_UP_CMP && below_start) begin
               idx_ff <= idx_ff + CW'(1);
            end
         end
         csds_pkg::ST_SWEEP: begin
            if (out_free) begin
               head_ff  <= top_ff;
               total_ff <= total_sat;
            end
         end
         csds_pkg::ST_RETURN: begin
            if (out_free) begin
               head_ff  <= '0;
               total_ff <= total_sat;
               idx_ff   <= '0;
            end
         end
         default: begin
         end
      endcase

      if (out_load) begin
         kind_ff     <= out_kind;
         from_ff     <= out_from;
         to_ff       <= out_to;
         mv_ff       <= out_mv;
         ovf_ff      <= drop_ff;
         if (out_kind == csds_pkg::KIND_SUMMARY) begin
            tot_out_ff  <= total_ff;
            seek_ff     <= csds_pkg::SEEK_W'(total_ff) * csds_pkg::SEEK_W'(ms_ff);
            last_out_ff <= 1'b1;
         end else begin
            tot_out_ff  <= total_sat;
            seek_ff     <= '0;
            last_out_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_from_cylinder  = from_ff;
   assign rsp_to_cylinder    = to_ff;
   assign rsp_movement       = mv_ff;
   assign rsp_total_movement = tot_out_ff;
   assign rsp_seek_time      = seek_ff;
   assign rsp_overflow       = ovf_ff;
   assign rsp_last_result    = last_out_ff;

   `CSDS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_FULL,
      "request count beyond capacity")
   `CSDS_ASSERT_NEXT(a_drop_on_full, clock, reset, req_fire && (count_ff == COUNT_FULL),
      drop_ff && (count_ff == COUNT_FULL), "full store did not drop the request")
   `CSDS_ASSERT_IMPL(a_no_overwrite, clock, reset, out_load, !rsp_valid_ff || rsp_ready,
      "pending record overwritten")
   `CSDS_ASSERT_IMPL(a_summary_last, clock, reset, rsp_valid_ff,
      (kind_ff == csds_pkg::KIND_SUMMARY) == last_out_ff, "last flag not tied to summary")

endmodule

// ===== verif/cscan_move_checker.sv =====
`timescale 1ns / 1ps
// Checker for the C-SCAN disk scheduler: watches the request, result and register ports,
// predicts the move records of every closed batch and compares them. Depends on csds_pkg.
module cscan_move_checker
   import csds_pkg::*;
#(
   parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [CYL_W-1:0]      req_cylinder,
   input  logic                  req_last_request,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [KIND_W-1:0]     rsp_kind,
   input  logic [CYL_W-1:0]      rsp_from_cylinder,
   input  logic [CYL_W-1:0]      rsp_to_cylinder,
   input  logic [COST_W-1:0]     rsp_movement,
   input  logic [TOTAL_W-1:0]    rsp_total_movement,
   input  logic [SEEK_W-1:0]     rsp_seek_time,
   input  logic                  rsp_overflow,
   input  logic                  rsp_last_result,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending,
   output int                    batch_count,
   output int                    overflow_batches,
   output int                    record_count
);

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CYL_W-1:0]   from_cyl;
      logic [CYL_W-1:0]   to_cyl;
      logic [COST_W-1:0]  movement;
      logic [TOTAL_W-1:0] total;
      logic [SEEK_W-1:0]  seek;
      logic               overflow;
      logic               last;
   } move_record_type;

   // register shadow
   logic [CYL_W-1:0]  cfg_start;
   logic [CYL_W-1:0]  cfg_top;
   logic [COST_W-1:0] cfg_return;
   logic [MS_W-1:0]   cfg_ms;

   // batch shadow
   logic [CYL_W-1:0]   sorted_cyl [MAX_REQUESTS];
   int                 stored_count;
   logic               dropped;
   logic [CYL_W-1:0]   head;
   logic [TOTAL_W-1:0] total;

   move_record_type expected_moves [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("record %0d %s got 0x%0h expected 0x%0h",
                                   record_count, name, got, want));
   endtask

   function automatic void add_movement(input int unsigned mv);
      int unsigned sum;
      sum = int'(total) + mv;
      total = (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);
   endfunction

   function automatic void push_move(input logic [KIND_W-1:0] kind,
                                     input logic [CYL_W-1:0] from_cyl,
                                     input logic [CYL_W-1:0] to_cyl,
                                     input logic [COST_W-1:0] mv,
                                     input logic [SEEK_W-1:0] seek,
                                     input logic last);
      move_record_type rec;
      rec.kind     = kind;
      rec.from_cyl = from_cyl;
      rec.to_cyl   = to_cyl;
      rec.movement = mv;
      rec.total    = total;
      rec.seek     = seek;
      rec.overflow = dropped;
      rec.last     = last;
      expected_moves.push_back(rec);
   endfunction

   function automatic void serve_stored(input int idx);
      logic [CYL_W-1:0] dest;
      logic [CYL_W-1:0] src;
      logic [COST_W-1:0] mv;
      dest = sorted_cyl[idx];
      src  = head;
      mv   = (dest > src) ? COST_W'(dest - src) : COST_W'(src - dest);
      add_movement(mv);
      head = dest;
      push_move(KIND_SERVE, src, dest, mv, '0, 1'b0);
   endfunction

   function automatic void clear_batch();
      stored_count = 0;
      dropped      = 1'b0;
      head         = cfg_start;
      total        = '0;
      foreach (sorted_cyl[i]) sorted_cyl[i] = '0;
   endfunction

   // Insert one request and, when it closes the batch, schedule the whole C-SCAN pass.
   task automatic schedule_request(input logic [CYL_W-1:0] cyl, input logic closes);
      int pos;
      int first;
      logic [COST_W-1:0] mv;
      logic [CYL_W-1:0] src;
      if (stored_count >= MAX_REQUESTS) begin
         dropped = 1'b1;
      end else begin
         pos = stored_count;
         while (pos > 0 && sorted_cyl[pos-1] > cyl) begin
            sorted_cyl[pos] = sorted_cyl[pos-1];
            pos--;
         end
         sorted_cyl[pos] = cyl;
         stored_count++;
      end
      if (!closes) return;

      head  = cfg_start;
      total = '0;
      first = 0;
      while (first < stored_count && sorted_cyl[first] < head) first++;
      for (int i = first; i < stored_count; i++) serve_stored(i);

      // sweep to the top end, even when the head is already beyond it
      src = head;
      mv  = (cfg_top > src) ? COST_W'(cfg_top - src) : COST_W'(src - cfg_top);
      add_movement(mv);
      head = cfg_top;
      push_move(KIND_SWEEP, src, cfg_top, mv, '0, 1'b0);

      add_movement(cfg_return);
      head = '0;
      push_move(KIND_RETURN, cfg_top, '0, cfg_return, '0, 1'b0);

      // the lower requests are exactly those skipped on the way up
      for (int i = 0; i < first; i++) serve_stored(i);

      push_move(KIND_SUMMARY, head, head, '0, SEEK_W'(total) * SEEK_W'(cfg_ms), 1'b1);
      batch_count++;
      if (dropped) overflow_batches++;
      clear_batch();
   endtask

   always @(posedge clock) begin
      move_record_type want;
      if (reset) begin
         cfg_start  = START_RST;
         cfg_top    = TOP_RST;
         cfg_return = RETURN_RST;
         cfg_ms     = MS_RST;
         clear_batch();
         expected_moves.delete();
         fail_count       = 0;
         batch_count      = 0;
         overflow_batches = 0;
         record_count     = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_START:  cfg_start  = csr_wdata[CYL_W-1:0];
               CSR_TOP:    cfg_top    = csr_wdata[CYL_W-1:0];
               CSR_RETURN: cfg_return = csr_wdata[COST_W-1:0];
               CSR_MS:     cfg_ms     = csr_wdata[MS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_moves.size() == 0) begin
               report_mismatch($sformatf("unexpected record, kind %0d", rsp_kind));
            end else begin
               want = expected_moves.pop_front();
               check_field("kind", rsp_kind, want.kind);
               check_field("from_cylinder", rsp_from_cylinder, want.from_cyl);
               check_field("to_cylinder", rsp_to_cylinder, want.to_cyl);
               check_field("movement", rsp_movement, want.movement);
               check_field("total_movement", rsp_total_movement, want.total);
               check_field("seek_time", rsp_seek_time, want.seek);
               check_field("overflow", rsp_overflow, want.overflow);
               check_field("last_result", rsp_last_result, want.last);
            end
            record_count++;
         end
         if (req_valid && req_ready)
            schedule_request(req_cylinder, req_last_request);
      end
      pending = expected_moves.size();
   end

endmodule

// ===== verif/tb_cscan_disk_scheduler_core.sv =====
`timescale 1ns / 1ps
// Testbench top for cscan_disk_scheduler_core: clock, reset, request batches, register
// settings and result back-pressure. Depends on csds_pkg, the core and cscan_move_checker.
module tb_cscan_disk_scheduler_core;
   import csds_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CYL_W-1:0]      req_cylinder = '0;
   logic                  req_last_request = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [CYL_W-1:0]      rsp_from_cylinder;
   logic [CYL_W-1:0]      rsp_to_cylinder;
   logic [COST_W-1:0]     rsp_movement;
   logic [TOTAL_W-1:0]    rsp_total_movement;
   logic [SEEK_W-1:0]     rsp_seek_time;
   logic                  rsp_overflow;
   logic                  rsp_last_result;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int batch_count;
   int overflow_batches;
   int record_count;

   int unsigned cyc = 0;
   int unsigned quiet_cycles = 0;
   int hold_requests = 0;
   int holds_done = 0;
   int items_sent = 0;
   int settings = 1;
   logic [CYL_W-1:0] cur_start = START_RST;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cscan_disk_scheduler_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cylinder       (req_cylinder),
      .req_last_request   (req_last_request),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_from_cylinder  (rsp_from_cylinder),
      .rsp_to_cylinder    (rsp_to_cylinder),
      .rsp_movement       (rsp_movement),
      .rsp_total_movement (rsp_total_movement),
      .rsp_seek_time      (rsp_seek_time),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_result    (rsp_last_result),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   cscan_move_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cylinder       (req_cylinder),
      .req_last_request   (req_last_request),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_from_cylinder  (rsp_from_cylinder),
      .rsp_to_cylinder    (rsp_to_cylinder),
      .rsp_movement       (rsp_movement),
      .rsp_total_movement (rsp_total_movement),
      .rsp_seek_time      (rsp_seek_time),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_result    (rsp_last_result),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending            (pending),
      .batch_count        (batch_count),
      .overflow_batches   (overflow_batches),
      .record_count       (record_count)
   );

   // no idling at all inside a window of the run
   function automatic bit draw_idle();
      return (cyc < 2500 || cyc >= 5500) && ($urandom_range(99) < 17);
   endfunction

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d records outstanding",
                  WATCHDOG_LIMIT, pending);
         $display("tb_cscan_disk_scheduler_core: FAIL");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (holds_done < hold_requests) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= !draw_idle();
      end
   end

   task automatic send_request(input logic [CYL_W-1:0] cyl, input logic closes);
      @(negedge clock);
      while (draw_idle()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_cylinder     <= cyl;
      req_last_request <= closes;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // drop valid, drain every expected record, then let any insertion walk finish
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_regs(input logic [CYL_W-1:0] start_cyl,
                               input logic [CYL_W-1:0] top_cyl,
                               input logic [COST_W-1:0] ret_cost,
                               input logic [MS_W-1:0] ms);
      write_reg(CSR_START, CSR_DATA_W'(start_cyl));
      write_reg(CSR_TOP, CSR_DATA_W'(top_cyl));
      write_reg(CSR_RETURN, ret_cost);
      write_reg(CSR_MS, CSR_DATA_W'(ms));
      cur_start = start_cyl;
      settings++;
   endtask

   initial begin
      int batch_no;
      int size;
      int tmp;
      logic [CYL_W-1:0] cyl;
      logic [CYL_W-1:0] prev;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: extremes, a request at the start position, duplicates, head ending above top
      send_request(12'd199, 1'b0);
      send_request(12'd0, 1'b0);
      send_request(12'd4095, 1'b0);
      send_request(12'd50, 1'b0);
      send_request(12'd50, 1'b0);
      send_request(12'd49, 1'b0);
      send_request(12'd51, 1'b1);
      // single upper request, then a single lower one
      send_request(12'd3000, 1'b1);
      send_request(12'd10, 1'b1);

      settle();
      program_regs(12'd0, 12'd4095, 13'd8191, 8'd255);
      send_request(12'd4095, 1'b0);
      send_request(12'd0, 1'b0);
      send_request(12'd2048, 1'b1);

      settle();
      program_regs(12'd4095, 12'd1, 13'd0, 8'd0);
      send_request(12'd4095, 1'b0);
      send_request(12'd1, 1'b0);
      send_request(12'd0, 1'b1);

      batch_no = 0;
      prev = '0;
      while (items_sent < 150) begin
         if (batch_no % 3 == 0) begin
            settle();
            case ($urandom_range(3))
               0: program_regs(12'd0, 12'd1, 13'd0, 8'd0);
               1: program_regs(12'd4095, 12'd4095, 13'd8191, 8'd255);
               default: program_regs(CYL_W'($urandom_range(4095)),
                                     CYL_W'($urandom_range(4095, 1)),
                                     COST_W'($urandom_range(8191)),
                                     MS_W'($urandom_range(255)));
            endcase
         end
         // a few batches overrun the store, most stay small
         if (batch_no % 8 == 2)
            size = $urandom_range(MAX_REQUESTS_DEF + 5, MAX_REQUESTS_DEF + 1);
         else if ($urandom_range(9) < 2)
            size = $urandom_range(MAX_REQUESTS_DEF, 12);
         else
            size = $urandom_range(8, 1);
         for (int k = 0; k < size; k++) begin
            case ($urandom_range(5))
               0: begin
                  tmp = int'(cur_start) + int'($urandom_range(4)) - 2;
                  cyl = (tmp < 0) ? '0 : (tmp > 4095) ? 12'd4095 : CYL_W'(tmp);
               end
               1: cyl = $urandom_range(1) ? 12'd4095 : 12'd0;
               2: cyl = prev;
               default: cyl = CYL_W'($urandom_range(4095));
            endcase
            send_request(cyl, k == size - 1);
            prev = cyl;
         end
         // stall the results of this batch while the next one is offered
         if (batch_no == 4) hold_requests++;
         batch_no++;
      end

      settle();
      $display("Run covered %0d batches (%0d overrunning the store), %0d requests,",
               batch_count, overflow_batches, items_sent);
      $display("%0d move records checked over %0d register settings.", record_count, settings);
      if (fail_count == 0)
         $display("tb_cscan_disk_scheduler_core: PASS");
      else
         $display("tb_cscan_disk_scheduler_core: FAIL");
      $finish;
   end

endmodule
